// ===== sv/rcfr_pkg.sv =====
// Package for the RC serial frame receiver: frame constants, register codes and shared types.
package rcfr_pkg;

	localparam int NUM_CHANNELS = 8;
	localparam int CHAN_W       = 16;
	localparam int BYTE_W       = 8;
	localparam int POS_W        = 5;
	localparam int FRAME_LEN    = 32;
	localparam int SUM_BYTES    = 30;
	localparam int CHAN_BASE    = 2;
	localparam int CH_BYTES     = 2 * NUM_CHANNELS;
	localparam int BIDX_W       = (CH_BYTES > 1) ? $clog2(CH_BYTES) : 1;
	localparam int ROW_W        = CHAN_W * NUM_CHANNELS;
	localparam int CFG_IDX_W    = 8;
	localparam int CFG_DATA_W   = 16;

	localparam logic [CHAN_W-1:0] SUM_INIT    = 16'hFFFF;
	localparam logic [CHAN_W-1:0] GAP_RESET   = 16'd3000;
	localparam logic [BYTE_W-1:0] SYNC_RESET  = 8'h20;
	localparam logic [POS_W-1:0]  POS_LAST    = POS_W'(FRAME_LEN - 1);
	localparam logic [POS_W-1:0]  POS_SUM_END = POS_W'(SUM_BYTES);
	localparam logic [POS_W-1:0]  POS_CHK_LO  = POS_W'(SUM_BYTES);
	localparam logic [POS_W-1:0]  POS_CH_LO   = POS_W'(CHAN_BASE);
	localparam logic [POS_W-1:0]  POS_CH_END  = POS_W'(CHAN_BASE + CH_BYTES);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GAP_LIMIT = 8'd0,
		CFG_SYNC      = 8'd1
	} cfg_idx_t;

	// Per-item decode handed from the frame tracker to the top level.
	typedef struct packed {
		logic              store_en;
		logic [BIDX_W-1:0] byte_idx;
		logic              last;
		logic              ok;
	} trk_t;

endpackage

// ===== sv/rcfr_if.sv =====
// Channel interfaces of the RC serial frame receiver: byte input, frame result and register write.
interface rcfr_in_if;
	import rcfr_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;
	logic [CHAN_W-1:0] gap_us;
	modport source (output valid, output rx_byte, output gap_us, input ready);
	modport sink (input valid, input rx_byte, input gap_us, output ready);
endinterface

interface rcfr_out_if;
	import rcfr_pkg::*;
	logic              valid;
	logic              ready;
	logic              frame_ok;
	logic [CHAN_W-1:0] chan0;
	logic [CHAN_W-1:0] chan1;
	logic [CHAN_W-1:0] chan2;
	logic [CHAN_W-1:0] chan3;
	logic [CHAN_W-1:0] chan4;
	logic [CHAN_W-1:0] chan5;
	logic [CHAN_W-1:0] chan6;
	logic [CHAN_W-1:0] chan7;
	modport source (output valid, output frame_ok, output chan0, output chan1, output chan2,
		output chan3, output chan4, output chan5, output chan6, output chan7, input ready);
	modport sink (input valid, input frame_ok, input chan0, input chan1, input chan2,
		input chan3, input chan4, input chan5, input chan6, input chan7, output ready);
endinterface

interface rcfr_cfg_if;
	import rcfr_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/rcfr_track.sv =====
// Frame tracker: position, running checksum and checksum compare for each received byte.
module rcfr_track
	import rcfr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              acc,
	input  logic [BYTE_W-1:0] rx_byte,
	input  logic [CHAN_W-1:0] gap_us,
	input  logic [CHAN_W-1:0] gap_limit,
	input  logic [BYTE_W-1:0] sync_val,
	output trk_t              trk
);

	logic [POS_W-1:0]  pos_q;
	logic [CHAN_W-1:0] sum_q;
	logic [BYTE_W-1:0] chk_lo_q;
	logic [POS_W-1:0]  pos;
	logic              drop;
	logic [CHAN_W-1:0] sum_base;

	always_comb begin
		pos      = (gap_us > gap_limit) ? '0 : pos_q;
		drop     = (pos == '0) && (rx_byte != sync_val);
		sum_base = (pos == '0) ? SUM_INIT : sum_q;
		trk.store_en = !drop && (pos >= POS_CH_LO) && (pos < POS_CH_END);
		trk.byte_idx = BIDX_W'(pos - POS_CH_LO);
		trk.last     = !drop && (pos == POS_LAST);
		trk.ok       = ({rx_byte, chk_lo_q} == sum_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			sum_q <= SUM_INIT;
		end else if (acc) begin
			if (drop) begin
				pos_q <= '0;
			end else if (pos == POS_LAST) begin
				pos_q <= '0;
				sum_q <= SUM_INIT;
			end else begin
				pos_q <= pos + POS_W'(1);
				if (pos < POS_SUM_END) begin
					sum_q <= sum_base - CHAN_W'(rx_byte);
				end else begin
					sum_q <= sum_base;
				end
			end
		end
	end

	// Low checksum byte; only ever read at the last position of a frame.
	always_ff @(posedge clk) begin
		if (acc && !drop && (pos == POS_CHK_LO)) begin
			chk_lo_q <= rx_byte;
		end
	end

endmodule

// ===== sv/rc_serial_frame_receiver.sv =====
// Top level of the RC serial frame receiver: channel bank memory, result pipeline and registers.
// A frame result passes through the bank read stage and then the output register.
// Throughput: one byte per cycle; the input stalls only while a finished result waits in the
// output register and a second one waits behind it in the bank read stage.
// Reset: position zero, checksum 0xFFFF, no good frame seen (channels read zero), registers
// at 3000 us gap limit and sync 0x20. The bank memory is not cleared; it needs no clearing pass.
module rc_serial_frame_receiver
	import rcfr_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	rcfr_in_if.sink   rx,
	rcfr_out_if.source res,
	rcfr_cfg_if.sink  cfg
);

	// Configuration registers. Writes are always taken.
	logic [CHAN_W-1:0] gap_limit_q;
	logic [BYTE_W-1:0] sync_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_limit_q <= GAP_RESET;
			sync_q      <= SYNC_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_GAP_LIMIT: gap_limit_q <= cfg.data;
				CFG_SYNC:      sync_q      <= cfg.data[BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	// Frame tracking runs on every accepted byte.
	logic acc;
	trk_t trk;

	assign acc = rx.valid && rx.ready;

	rcfr_track u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.rx_byte   (rx.rx_byte),
		.gap_us    (rx.gap_us),
		.gap_limit (gap_limit_q),
		.sync_val  (sync_q),
		.trk       (trk)
	);

	// The channel bytes of a frame are written into the inactive row of a two-row memory.
	// When the checksum of a frame matches, that row becomes the active one, so the
	// latched channels are never disturbed by a frame that is still being collected.
	logic [ROW_W-1:0] bank_mem [2];
	logic             act_q;
	logic             good_q;
	logic             rd_bank;

	assign rd_bank = trk.ok ? ~act_q : act_q;

	always_ff @(posedge clk) begin
		if (acc && trk.store_en) begin
			bank_mem[~act_q][BYTE_W*trk.byte_idx +: BYTE_W] <= rx.rx_byte;
		end
	end

	// Bank read stage: the row that holds the channels to report is read when the last
	// byte of a frame is accepted, and the registered data waits here for the output.
	logic [ROW_W-1:0] rd_row_s1;
	logic             vld_s1;
	logic             ok_s1;
	logic             good_s1;

	always_ff @(posedge clk) begin
		if (acc && trk.last) begin
			rd_row_s1 <= bank_mem[rd_bank];
		end
	end

	// Output register.
	logic              out_vld_q;
	logic              out_ok_q;
	logic [CHAN_W-1:0] out_chan_q [8];
	logic [CHAN_W-1:0] chan_s1 [8];
	logic              move;

	assign move     = vld_s1 && (!out_vld_q || res.ready);
	assign rx.ready = !(vld_s1 && out_vld_q && !res.ready);

	// Unused lanes, and all lanes before the first good frame, read zero.
	for (genvar k = 0; k < 8; k++) begin : g_lane
		if (k < NUM_CHANNELS) begin : g_used
			assign chan_s1[k] = good_s1 ? rd_row_s1[CHAN_W*k +: CHAN_W] : '0;
		end else begin : g_unused
			assign chan_s1[k] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q     <= 1'b0;
			good_q    <= 1'b0;
			vld_s1    <= 1'b0;
			ok_s1     <= 1'b0;
			good_s1   <= 1'b0;
			out_vld_q <= 1'b0;
			out_ok_q  <= 1'b0;
		end else begin
			if (move) begin
				vld_s1    <= 1'b0;
				out_vld_q <= 1'b1;
				out_ok_q  <= ok_s1;
			end else if (res.ready) begin
				out_vld_q <= 1'b0;
			end
			if (acc && trk.last) begin
				vld_s1  <= 1'b1;
				ok_s1   <= trk.ok;
				good_s1 <= good_q || trk.ok;
				if (trk.ok) begin
					act_q  <= ~act_q;
					good_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_chan_q <= chan_s1;
		end
	end

	assign res.valid    = out_vld_q;
	assign res.frame_ok = out_ok_q;
	assign res.chan0    = out_chan_q[0];
	assign res.chan1    = out_chan_q[1];
	assign res.chan2    = out_chan_q[2];
	assign res.chan3    = out_chan_q[3];
	assign res.chan4    = out_chan_q[4];
	assign res.chan5    = out_chan_q[5];
	assign res.chan6    = out_chan_q[6];
	assign res.chan7    = out_chan_q[7];

endmodule
